### src/arr_pkg.sv
// Shared widths, codes and table entry type for the address range resolver.
package arr_pkg;

	localparam int DEV_W    = 48;
	localparam int LEN_W    = 40;
	localparam int HOST_W   = 48;
	localparam int STATUS_W = 3;
	localparam int USED_W   = 7;

	localparam logic REQ_INSERT  = 1'b0;
	localparam logic REQ_RESOLVE = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_REJECTED = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_HIT      = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_MISS     = 3'd4;

	typedef struct packed {
		logic [DEV_W-1:0]  dev_base;
		logic [LEN_W-1:0]  size;
		logic [HOST_W-1:0] host_base;
	} entry_t;

endpackage

### src/arr_req_if.sv
// Request channel: insert or resolve items with valid/ready handshake.
interface arr_req_if;
	import arr_pkg::*;

	logic              valid;
	logic              ready;
	logic              req_type;
	logic [DEV_W-1:0]  dev_addr;
	logic [LEN_W-1:0]  span_len;
	logic [HOST_W-1:0] host_base;
	logic              host_visible;

	modport source (
		output valid, req_type, dev_addr, span_len, host_base, host_visible,
		input  ready
	);

	modport sink (
		input  valid, req_type, dev_addr, span_len, host_base, host_visible,
		output ready
	);

endinterface

### src/arr_rsp_if.sv
// Response channel: status, host address and entry count with valid/ready handshake.
interface arr_rsp_if;
	import arr_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [HOST_W-1:0]   host_addr;
	logic [USED_W-1:0]   entries_used;

	modport source (
		output valid, status, host_addr, entries_used,
		input  ready
	);

	modport sink (
		input  valid, status, host_addr, entries_used,
		output ready
	);

endinterface

### src/arr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module arr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/address_range_resolver_top.sv
// Address range resolver: region table with newest-first span lookup.
//
// Channels: req (sink) takes insert and resolve items, rsp (source) returns
// one result per item; a transfer happens when valid and ready are both high.
// An insert stores device base, size and host base in the next free slot of
// the table RAM and answers on the edge after its transfer (inserted,
// rejected when not host-visible or an address is zero, or full).
// A resolve with a zero address, zero length or an empty table answers a
// miss on the edge after its transfer. Otherwise the sequencer reads one
// table entry per cycle from the newest to the oldest through the RAM read
// port and a shared subtract/compare unit; each entry passes the registered
// RAM read data and the compare register stage; the first hit, or a miss after
// the oldest entry, loads the output register. One item is in work at a time;
// req.ready is low during a scan and while a result waits in the output
// register and the receiver holds rsp.ready low. Reset clears the entry count,
// the sequencer and the output valid; table contents stay as they are and are
// never read before they are written.
module address_range_resolver_top #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	arr_req_if.sink   req,
	arr_rsp_if.source rsp
);
	import arr_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic             state_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic             issuing_q;
	logic             v_s1, last_s1;
	logic             v_s2, last_s2;
	logic             rsp_valid_q;

	logic [DEV_W-1:0] addr_q;
	logic [LEN_W-1:0] len_q;

	logic              ge_s2, fit_s2;
	logic [DEV_W-1:0]  off_s2;
	logic [LEN_W-1:0]  room_s2;
	logic [HOST_W-1:0] hbase_s2;

	logic [STATUS_W-1:0] status_q;
	logic [HOST_W-1:0]   host_addr_q;
	logic [USED_W-1:0]   used_q;

	logic                 req_fire;
	logic                 is_insert;
	logic                 ins_bad, full, ins_ok;
	logic                 res_trivial;
	logic                 hit_w, end_miss, done;
	logic                 out_load;
	logic [STATUS_W-1:0]  out_status;
	logic [HOST_W-1:0]    out_host;
	logic [USED_W-1:0]    out_used;
	logic                 ram_we, ram_re;
	entry_t               wr_entry, rd_entry;
	logic [$bits(entry_t)-1:0] ram_rdata;
	logic [DEV_W:0]       diff;
	logic [LEN_W:0]       room;

	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign req_fire  = req.valid && req.ready;

	assign is_insert   = (req.req_type == REQ_INSERT);
	assign ins_bad     = !req.host_visible || (req.dev_addr == '0) || (req.host_base == '0);
	assign full        = (count_q >= CNT_W'(TABLE_DEPTH));
	assign ins_ok      = !ins_bad && !full;
	assign res_trivial = (req.dev_addr == '0) || (req.span_len == '0) || (count_q == '0);

	assign hit_w    = v_s2 && ge_s2 && fit_s2 &&
		(off_s2 <= {{(DEV_W-LEN_W){1'b0}}, room_s2});
	assign end_miss = v_s2 && !hit_w && last_s2;
	assign done     = hit_w || end_miss;

	assign ram_we   = req_fire && is_insert && ins_ok;
	assign ram_re   = (state_q == S_SCAN) && issuing_q;
	assign wr_entry = '{dev_base: req.dev_addr, size: req.span_len, host_base: req.host_base};
	assign rd_entry = entry_t'(ram_rdata);

	arr_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	assign diff = {1'b0, addr_q} - {1'b0, rd_entry.dev_base};
	assign room = {1'b0, rd_entry.size} - {1'b0, len_q};

	assign out_load = (req_fire && (is_insert || res_trivial)) || done;

	always_comb begin
		out_host = '0;
		out_used = USED_W'(count_q);
		if (hit_w) begin
			out_status = STAT_HIT;
			out_host   = hbase_s2 + off_s2;
		end else if (end_miss || !is_insert) begin
			out_status = STAT_MISS;
		end else if (ins_bad) begin
			out_status = STAT_REJECTED;
		end else if (full) begin
			out_status = STAT_FULL;
		end else begin
			out_status = STAT_INSERTED;
			out_used   = USED_W'(count_q + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_ptr_q    <= '0;
			issuing_q   <= 1'b0;
			v_s1        <= 1'b0;
			last_s1     <= 1'b0;
			v_s2        <= 1'b0;
			last_s2     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						if (ram_we) begin
							count_q <= count_q + 1'b1;
						end
						if (!is_insert && !res_trivial) begin
							state_q   <= S_SCAN;
							issuing_q <= 1'b1;
							rd_ptr_q  <= IDX_W'(count_q - 1'b1);
						end
					end
				end
				S_SCAN: begin
					if (done) begin
						state_q   <= S_IDLE;
						issuing_q <= 1'b0;
						v_s1      <= 1'b0;
						v_s2      <= 1'b0;
					end else begin
						v_s1    <= issuing_q;
						last_s1 <= issuing_q && (rd_ptr_q == '0);
						if (issuing_q) begin
							if (rd_ptr_q == '0) begin
								issuing_q <= 1'b0;
							end else begin
								rd_ptr_q <= rd_ptr_q - 1'b1;
							end
						end
						v_s2    <= v_s1;
						last_s2 <= last_s1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			addr_q <= req.dev_addr;
			len_q  <= req.span_len;
		end
		if (v_s1) begin
			ge_s2    <= !diff[DEV_W];
			fit_s2   <= !room[LEN_W];
			off_s2   <= diff[DEV_W-1:0];
			room_s2  <= room[LEN_W-1:0];
			hbase_s2 <= rd_entry.host_base;
		end
		if (out_load) begin
			status_q    <= out_status;
			host_addr_q <= out_host;
			used_q      <= out_used;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.host_addr    = host_addr_q;
	assign rsp.entries_used = used_q;

`ifndef SYNTH
	a_done_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && done) |-> !rsp_valid_q)
		else $error("scan finished while a result is still held");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !req.ready)
		else $error("request taken during a scan");

	a_pipe_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2) |-> (state_q == S_SCAN))
		else $error("scan pipeline active outside a scan");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |=> $stable(count_q))
		else $error("entry count changed during a scan");
`endif

endmodule

### bench/address_range_resolver_top_tb.sv
// Self-checking bench for the address range resolver: directed and random inserts and lookups.
module address_range_resolver_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import arr_pkg::*;

	localparam int TABLE_DEPTH   = 64;
	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 8;
	localparam int RANDOM_ITEMS  = 1400;
	localparam int IDLE_PCT      = 32;
	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 100;

	typedef struct packed {
		logic              req_type;
		logic [DEV_W-1:0]  dev_addr;
		logic [LEN_W-1:0]  span_len;
		logic [HOST_W-1:0] host_base;
		logic              host_visible;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HOST_W-1:0]   host_addr;
		logic [USED_W-1:0]   entries_used;
	} resolution_t;

	class resolver_scoreboard;
		entry_t      regions[TABLE_DEPTH];
		int unsigned used;
		resolution_t pending[$];
		int unsigned errors;

		function resolution_t translate(request_t r);
			resolution_t       res;
			logic [HOST_W-1:0] offset;
			res.status    = STAT_MISS;
			res.host_addr = '0;
			if (r.req_type == REQ_INSERT) begin
				if (!r.host_visible || r.dev_addr == '0 || r.host_base == '0) begin
					res.status = STAT_REJECTED;
				end else if (used >= TABLE_DEPTH) begin
					res.status = STAT_FULL;
				end else begin
					regions[used].dev_base  = r.dev_addr;
					regions[used].size      = r.span_len;
					regions[used].host_base = r.host_base;
					used++;
					res.status = STAT_INSERTED;
				end
			end else if (r.dev_addr != '0 && r.span_len != '0) begin
				for (int i = int'(used) - 1; i >= 0; i--) begin
					if (r.dev_addr >= regions[i].dev_base && r.span_len <= regions[i].size) begin
						offset = r.dev_addr - regions[i].dev_base;
						if (offset <= HOST_W'(regions[i].size - r.span_len)) begin
							res.status    = STAT_HIT;
							res.host_addr = regions[i].host_base + offset;
							break;
						end
					end
				end
			end
			res.entries_used = USED_W'(used);
			return res;
		endfunction

		function void note_request(request_t r);
			pending = {pending, translate(r)};
		endfunction

		function void check_response(resolution_t got);
			resolution_t want;
			if (pending.size() == 0) begin
				$error("result with nothing pending: status %0d host_addr %h entries_used %0d",
					got.status, got.host_addr, got.entries_used);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.host_addr !== want.host_addr) begin
				$error("host_addr: expected %h, got %h", want.host_addr, got.host_addr);
				errors++;
			end
			if (got.entries_used !== want.entries_used) begin
				$error("entries_used: expected %0d, got %0d", want.entries_used,
					got.entries_used);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   steady_phase;

	arr_req_if req();
	arr_rsp_if rsp();

	resolver_scoreboard sb = new();

	address_range_resolver_top #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [63:0] wide_random();
		return {$urandom, $urandom};
	endfunction

	function automatic request_t make_item(logic kind, logic [DEV_W-1:0] addr,
		logic [LEN_W-1:0] len, logic [HOST_W-1:0] host, logic vis);
		request_t it;
		it.req_type     = kind;
		it.dev_addr     = addr;
		it.span_len     = len;
		it.host_base    = host;
		it.host_visible = vis;
		return it;
	endfunction

	function automatic request_t random_insert();
		request_t    it;
		int unsigned pick;
		it = make_item(REQ_INSERT, DEV_W'(wide_random()), '0, HOST_W'(wide_random()), 1'b1);
		pick = $urandom_range(99);
		if (pick < 10)
			it.span_len = '0;
		else if (pick < 70)
			it.span_len = LEN_W'($urandom_range(1, 65535));
		else
			it.span_len = LEN_W'(wide_random());
		pick = $urandom_range(99);
		if (pick < 30 && sb.used != 0)
			it.dev_addr = sb.regions[$urandom_range(sb.used - 1)].dev_base
				+ DEV_W'($urandom_range(255));
		else if (pick < 35)
			it.dev_addr = '1 - DEV_W'($urandom_range(4095));
		if (it.dev_addr == '0)
			it.dev_addr = DEV_W'(1);
		if ($urandom_range(9) == 0)
			it.host_base = '1 - HOST_W'($urandom_range(65535));
		if (it.host_base == '0)
			it.host_base = HOST_W'(1);
		if ($urandom_range(4) == 0) begin
			case ($urandom_range(2))
				0: it.host_visible = 1'b0;
				1: it.dev_addr = '0;
				default: it.host_base = '0;
			endcase
		end
		return it;
	endfunction

	function automatic request_t random_resolve();
		request_t    it;
		entry_t      region;
		logic [63:0] len;
		logic [63:0] off;
		logic [63:0] size;
		int unsigned pick;
		it = make_item(REQ_RESOLVE, DEV_W'(wide_random()), LEN_W'(wide_random()),
			HOST_W'(wide_random()), 1'($urandom_range(1)));
		pick = $urandom_range(99);
		if (sb.used == 0 || pick >= 75) begin
			if ($urandom_range(7) == 0)
				it.dev_addr = '0;
			if ($urandom_range(7) == 0)
				it.span_len = '0;
			else if ($urandom_range(1))
				it.span_len = LEN_W'($urandom_range(1, 256));
			return it;
		end
		region = sb.regions[$urandom_range(sb.used - 1)];
		size   = 64'(region.size);
		if (size == 0) begin
			it.dev_addr = region.dev_base;
			it.span_len = LEN_W'(1);
			return it;
		end
		if ($urandom_range(1))
			len = 1 + wide_random() % size;
		else
			len = 1 + wide_random() % (size < 64 ? size : 64'd64);
		off = wide_random() % (size - len + 1);
		if (pick >= 55) begin
			case ($urandom_range(3))
				0: begin
					len = 1;
					off = size;
				end
				1: begin
					len = 1;
					off = '1;
				end
				2: begin
					len = size + 1;
					off = 0;
				end
				default: off = size - len;
			endcase
		end
		it.dev_addr = region.dev_base + DEV_W'(off);
		it.span_len = LEN_W'(len);
		return it;
	endfunction

	task automatic send_request(input request_t it);
		while (!steady_phase && $urandom_range(99) < IDLE_PCT) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid        <= 1'b1;
		req.req_type     <= it.req_type;
		req.dev_addr     <= it.dev_addr;
		req.span_len     <= it.span_len;
		req.host_base    <= it.host_base;
		req.host_visible <= it.host_visible;
		@(posedge clk);
		while (req.ready !== 1'b1)
			@(posedge clk);
		sb.note_request(it);
	endtask

	task automatic drain_results();
		req.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= steady_phase || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
			sb.check_response({rsp.status, rsp.host_addr, rsp.entries_used});
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req.valid === 1'b1 && req.ready === 1'b1)
				|| (rsp.valid === 1'b1 && rsp.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n           <= 1'b0;
		steady_phase     <= 1'b0;
		req.valid        <= 1'b0;
		req.req_type     <= REQ_INSERT;
		req.dev_addr     <= '0;
		req.span_len     <= '0;
		req.host_base    <= '0;
		req.host_visible <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(make_item(REQ_RESOLVE, 48'h1000, 40'h10, 48'h0, 1'b0));
		send_request(make_item(REQ_INSERT, 48'h1000, 40'h100, 48'h8000_0000, 1'b0));
		send_request(make_item(REQ_INSERT, 48'h0, 40'h100, 48'h8000_0000, 1'b1));
		send_request(make_item(REQ_INSERT, 48'h1000, 40'h100, 48'h0, 1'b1));
		send_request(make_item(REQ_INSERT, 48'h1000, 40'h100, 48'h8000_0000, 1'b1));
		send_request(make_item(REQ_RESOLVE, 48'h1000, 40'h100, 48'h0, 1'b0));
		send_request(make_item(REQ_RESOLVE, 48'h1001, 40'h100, 48'h0, 1'b0));
		send_request(make_item(REQ_RESOLVE, 48'h0FFF, 40'h1, 48'h0, 1'b1));
		send_request(make_item(REQ_RESOLVE, 48'h0, 40'h1, 48'h0, 1'b0));
		send_request(make_item(REQ_RESOLVE, 48'h1000, 40'h0, 48'h0, 1'b0));
		send_request(make_item(REQ_INSERT, 48'h1080, 40'h100, 48'h9000, 1'b1));
		send_request(make_item(REQ_RESOLVE, 48'h10C0, 40'h10, 48'h0, 1'b0));
		send_request(make_item(REQ_RESOLVE, 48'h1010, 40'h10, 48'h0, 1'b0));
		send_request(make_item(REQ_INSERT, 48'h2000, 40'h0, 48'h1234, 1'b1));
		send_request(make_item(REQ_RESOLVE, 48'h2000, 40'h1, 48'h0, 1'b0));
		send_request(make_item(REQ_INSERT, 48'hFF00_0000_0000, 40'hFF_FFFF_FFFF,
			48'hFFFF_FFFF_FF00, 1'b1));
		send_request(make_item(REQ_RESOLVE, 48'hFF00_0000_0100, 40'h1, 48'h0, 1'b0));
		send_request(make_item(REQ_RESOLVE, 48'hFFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF,
			48'hFFFF_FFFF_FFFF, 1'b1));
		send_request(make_item(REQ_INSERT, 48'hFFFF_FFFF_FFFF, 40'h1, 48'h1, 1'b1));
		send_request(make_item(REQ_RESOLVE, 48'hFFFF_FFFF_FFFF, 40'h1, 48'h0, 1'b0));
		send_request(make_item(REQ_RESOLVE, 48'hFF00_0000_0000, 40'hFF_FFFF_FFFF, 48'h0,
			1'b0));
		drain_results();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 500)
				steady_phase <= 1'b1;
			else if (n == 700)
				steady_phase <= 1'b0;
			if ($urandom_range(99) < 10)
				send_request(random_insert());
			else
				send_request(random_resolve());
			if (n % 350 == 349)
				drain_results();
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
